// ===== rtl/tach_pkg.sv =====
// Shared widths, constants, register indexes and state types of the tachometer.
package tach_pkg;

   // Field widths of the sample and result transactions.
   localparam int CH_W    = 1;
   localparam int CNT_W   = 15;
   localparam int TS_W    = 48;
   localparam int RPM_W   = 20;
   localparam int TOTAL_W = 32;

   // Configuration registers.
   localparam int PPR_W      = 8;
   localparam int TMO_W      = 16;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_PPR     = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT = 1'd1;

   localparam logic [PPR_W-1:0] PPR_RESET = 8'd1;
   localparam logic [TMO_W-1:0] TMO_RESET = 16'd1000;

   // Speed arithmetic: 60 s/min * 1e6 us/s * 16 sixteenths = 960000000.
   localparam int                 SCALE_W       = 30;
   localparam logic [SCALE_W-1:0] SCALE_X16     = 30'd960000000;
   localparam logic [RPM_W-1:0]   RPM_MAX       = 20'd1048575;
   localparam logic [RPM_W-1:0]   CROSSOVER_X16 = 20'd9600;
   localparam int                 QBITS         = RPM_W;

   // Timeout limit in microseconds: up to 65535 * 1000.
   localparam int               US_W      = 10;
   localparam logic [US_W-1:0]  US_PER_MS = 10'd1000;
   localparam int               LIM_W     = 26;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_DELTA,
      ST_DEC,
      ST_DIV,
      ST_OUT
   } tach_state_type;

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_MUL,
      DIV_DIV,
      DIV_DONE
   } div_state_type;

endpackage

// ===== rtl/tach_req_if.sv =====
// Sample channel: valid/ready handshake carrying one tachometer sample.
interface tach_req_if;
   import tach_pkg::*;

   logic             valid;
   logic             ready;
   logic [CH_W-1:0]  channel;
   logic [CNT_W-1:0] pulse_count;
   logic [TS_W-1:0]  timestamp_us;

   modport source (output valid, output channel, output pulse_count,
                   output timestamp_us, input ready);
   modport sink   (input valid, input channel, input pulse_count,
                   input timestamp_us, output ready);
endinterface

// ===== rtl/tach_rsp_if.sv =====
// Result channel: valid/ready handshake carrying one speed measurement.
interface tach_rsp_if;
   import tach_pkg::*;

   logic               valid;
   logic               ready;
   logic [RPM_W-1:0]   rpm_x16;
   logic               stopped;
   logic               period_est;
   logic [TOTAL_W-1:0] pulse_tally;

   modport source (output valid, output rpm_x16, output stopped,
                   output period_est, output pulse_tally, input ready);
   modport sink   (input valid, input rpm_x16, input stopped,
                   input period_est, input pulse_tally, output ready);
endinterface

// ===== rtl/tach_div.sv =====
// Bit-serial speed unit: shift-add products, then a restoring divide one bit a cycle.
module tach_div #(
   parameter int CW = 15,
   parameter int TW = 48
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [CW-1:0]               delta,
   input  logic [TW-1:0]               gate,
   input  logic [tach_pkg::PPR_W-1:0]  ppr,
   output logic                        done,
   output logic [tach_pkg::RPM_W-1:0]  quot
);
   import tach_pkg::*;

   localparam int NW = CW + SCALE_W;
   localparam int DW = TW + PPR_W + QBITS;
   localparam int SW = (CW > QBITS) ? $clog2(CW) : $clog2(QBITS + 1);

   div_state_type    state_ff, state_in;
   logic [NW-1:0]    num_ff;
   logic [NW-1:0]    mcand_ff;
   logic [CW-1:0]    mult_ff;
   logic [DW-1:0]    den_ff;
   logic [DW-1:0]    gsh_ff;
   logic [PPR_W-1:0] ppr_ff;
   logic [SW-1:0]    step_ff;
   logic [QBITS-1:0] q_ff;
   logic             sat_ff;
   logic             ge;

   // Remainder against the shifted divisor.
   assign ge = ({{(DW-NW){1'b0}}, num_ff} >= den_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         DIV_IDLE: begin
            if (start) state_in = DIV_MUL;
         end
         DIV_MUL: begin
            if (step_ff == '0) state_in = DIV_DIV;
         end
         DIV_DIV: begin
            if ((step_ff == SW'(QBITS) && ge) || step_ff == '0) state_in = DIV_DONE;
         end
         DIV_DONE: begin
            state_in = DIV_IDLE;
         end
         default: state_in = DIV_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         DIV_IDLE: begin
            if (start) begin
               num_ff   <= '0;
               mcand_ff <= NW'(SCALE_X16);
               mult_ff  <= delta;
               den_ff   <= '0;
               gsh_ff   <= {{PPR_W{1'b0}}, gate, {QBITS{1'b0}}};
               ppr_ff   <= ppr;
               step_ff  <= SW'(CW - 1);
            end
         end
         DIV_MUL: begin
            // Numerator delta*scale and divisor (gate*ppr)<<QBITS, one bit each.
            if (mult_ff[0]) num_ff <= num_ff + mcand_ff;
            if (ppr_ff[0])  den_ff <= den_ff + gsh_ff;
            mcand_ff <= mcand_ff << 1;
            gsh_ff   <= gsh_ff << 1;
            mult_ff  <= mult_ff >> 1;
            ppr_ff   <= ppr_ff >> 1;
            if (step_ff == '0) begin
               step_ff <= SW'(QBITS);
               q_ff    <= '0;
               sat_ff  <= 1'b0;
            end else begin
               step_ff <= step_ff - 1'b1;
            end
         end
         DIV_DIV: begin
            if (step_ff == SW'(QBITS)) begin
               // A quotient bit above the field means the speed saturates.
               if (ge) sat_ff <= 1'b1;
            end else begin
               if (ge) num_ff <= num_ff - den_ff[NW-1:0];
               q_ff <= {q_ff[QBITS-2:0], ge};
            end
            den_ff <= den_ff >> 1;
            if (step_ff != '0) step_ff <= step_ff - 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign done = (state_ff == DIV_DONE);
   assign quot = sat_ff ? RPM_MAX : q_ff;

endmodule

// ===== rtl/dual_mode_tachometer.sv =====
// Top level of the dual-mode tachometer: per-channel state, sequencer and result register.
//
// Each sample transaction names a channel, gives that channel's wrapping pulse-counter
// reading and a microsecond timestamp, and yields one result transaction (samples for a
// channel at or beyond CHANNELS are accepted and dropped). The pulse delta since the
// channel's previous sample is taken modulo COUNTER_MAX+1 and added to a 32-bit wrapping
// total. When no edge has been seen for the configured number of milliseconds the result
// reports stopped with speed zero. Otherwise the speed in sixteenths of RPM is
// delta*960000000/(gate*pulses per revolution), truncated and saturating at 1048575,
// where the gate is the time since the channel's previous sample; results below 600 RPM
// carry the period-estimator flag, and a period-mode sample without pulses repeats the
// last speed. The block works on one sample at a time. A sample without pulses, or one
// that reports stopped, goes from the decision state straight to the output state. A
// sample with pulses passes through the speed unit first: it forms its products by
// shift-and-add over one delta bit a cycle and then divides with one quotient bit a
// cycle, plus a saturation check. When that check already finds the quotient too large
// for the field, the division ends there. The finished result waits in an output
// register, so the next sample is accepted while the previous result is still
// waiting to be taken. Configuration registers take effect for samples accepted after
// the write.
module dual_mode_tachometer #(
   parameter int CHANNELS    = 2,
   parameter int COUNTER_MAX = 32767,
   parameter int TIME_BITS   = 48
) (
   input  logic                             clock,
   input  logic                             reset,
   tach_req_if.sink                         req_bus,
   tach_rsp_if.source                       rsp_bus,
   input  logic                             csr_we,
   input  logic [tach_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tach_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import tach_pkg::*;

   localparam int TW        = TIME_BITS;
   localparam int CW        = $clog2(COUNTER_MAX + 1);
   localparam int CHW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int RED_W     = 24;
   localparam int RED_STEPS = 8;
   localparam logic [RED_W-1:0] MOD_RED = RED_W'(COUNTER_MAX + 1);
   localparam logic [CW:0]      MOD_CW  = (CW + 1)'(COUNTER_MAX + 1);

   // Configuration registers and the timeout expressed in microseconds.
   logic [PPR_W-1:0] ppr_ff;
   logic [TMO_W-1:0] tmo_ff;
   logic [LIM_W-1:0] limit_ff;

   // Per-channel state.
   logic [CW-1:0]      prev_count_ff  [CHANNELS];
   logic [TW-1:0]      prev_time_ff   [CHANNELS];
   logic [TW-1:0]      last_edge_ff   [CHANNELS];
   logic [TOTAL_W-1:0] pulse_total_ff [CHANNELS];
   logic [RPM_W-1:0]   held_rpm_ff    [CHANNELS];

   // Sample being worked on.
   tach_state_type   state_ff, state_in;
   logic [CHW-1:0]   idx_ff;
   logic [CNT_W-1:0] cnt_raw_ff;
   logic [TS_W-1:0]  ts_ff;
   logic [CW-1:0]    cnt_red_ff;
   logic [CW-1:0]    delta_ff;
   logic [TW-1:0]    gate_ff;
   logic [TW-1:0]    elapsed_ff;

   // Finished result, then the output register.
   logic [RPM_W-1:0]   res_rpm_ff;
   logic               res_stop_ff;
   logic               res_pmode_ff;
   logic [TOTAL_W-1:0] res_total_ff;
   logic               rsp_valid_ff;
   logic [RPM_W-1:0]   rsp_rpm_ff;
   logic               rsp_stop_ff;
   logic               rsp_pmode_ff;
   logic [TOTAL_W-1:0] rsp_total_ff;

   logic               req_take;
   logic               ch_ok;
   logic [TW-1:0]      now_w;
   logic [RED_W-1:0]   red_v;
   logic [CW:0]        diff_w;
   logic               delta_nz;
   logic               stop_w;
   logic [TOTAL_W-1:0] total_sum;
   logic               div_start;
   logic               div_done;
   logic [RPM_W-1:0]   div_quot;
   logic               out_load;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_take      = req_bus.valid && req_bus.ready;
   assign ch_ok         = (32'(req_bus.channel) < CHANNELS);

   // The timestamp is taken modulo 2^TIME_BITS.
   generate
      if (TW <= TS_W) begin : g_now_trim
         assign now_w = ts_ff[TW-1:0];
      end else begin : g_now_ext
         assign now_w = {{(TW-TS_W){1'b0}}, ts_ff};
      end
   endgenerate

   // Reduce the counter reading modulo COUNTER_MAX+1 by conditional subtraction of the
   // modulus scaled by decreasing powers of two; the reading is never more than
   // 2^RED_STEPS times the smallest modulus.
   always_comb begin
      red_v = {{(RED_W-CNT_W){1'b0}}, cnt_raw_ff};
      for (int k = RED_STEPS - 1; k >= 0; k--) begin
         if (red_v >= (MOD_RED << k)) red_v = red_v - (MOD_RED << k);
      end
   end

   // Counter delta with wrap-around.
   always_comb begin
      diff_w = {1'b0, cnt_red_ff} - {1'b0, prev_count_ff[idx_ff]};
      if (diff_w[CW]) diff_w = diff_w + MOD_CW;
   end

   // A sample with pulses stamps the edge time with its own timestamp, so its elapsed
   // time is zero and it is stopped only when the timeout itself is zero.
   assign delta_nz  = (delta_ff != '0);
   assign stop_w    = delta_nz ? (limit_ff == '0) : (elapsed_ff >= TW'(limit_ff));
   assign total_sum = pulse_total_ff[idx_ff] + TOTAL_W'(delta_ff);
   assign out_load  = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      div_start = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_take && ch_ok) state_in = ST_PREP;
         end
         ST_PREP: begin
            state_in = ST_DELTA;
         end
         ST_DELTA: begin
            state_in = ST_DEC;
         end
         ST_DEC: begin
            if (!stop_w && delta_nz) begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_DIV: begin
            if (div_done) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         ppr_ff <= PPR_RESET;
         tmo_ff <= TMO_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PPR:     ppr_ff <= csr_wdata[PPR_W-1:0];
            CSR_TIMEOUT: tmo_ff <= csr_wdata[TMO_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      limit_ff <= LIM_W'({{(LIM_W-TMO_W){1'b0}}, tmo_ff} * LIM_W'(US_PER_MS));
   end

   // Sample datapath.
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               idx_ff     <= CHW'(req_bus.channel);
               cnt_raw_ff <= req_bus.pulse_count;
               ts_ff      <= req_bus.timestamp_us;
            end
         end
         ST_PREP: begin
            cnt_red_ff <= red_v[CW-1:0];
         end
         ST_DELTA: begin
            delta_ff   <= diff_w[CW-1:0];
            gate_ff    <= now_w - prev_time_ff[idx_ff];
            elapsed_ff <= now_w - last_edge_ff[idx_ff];
         end
         ST_DEC: begin
            res_total_ff <= total_sum;
            res_stop_ff  <= stop_w;
            if (stop_w) begin
               res_rpm_ff   <= '0;
               res_pmode_ff <= 1'b0;
            end else if (!delta_nz) begin
               // Period mode without pulses repeats the last speed.
               res_rpm_ff   <= held_rpm_ff[idx_ff];
               res_pmode_ff <= 1'b1;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               res_rpm_ff   <= div_quot;
               res_pmode_ff <= (div_quot < CROSSOVER_X16);
            end
         end
         default: begin
         end
      endcase
   end

   // Per-channel state updates.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            prev_count_ff[i]  <= '0;
            prev_time_ff[i]   <= '0;
            last_edge_ff[i]   <= '0;
            pulse_total_ff[i] <= '0;
            held_rpm_ff[i]    <= '0;
         end
      end else begin
         case (state_ff)
            ST_DELTA: begin
               prev_count_ff[idx_ff] <= cnt_red_ff;
               prev_time_ff[idx_ff]  <= now_w;
            end
            ST_DEC: begin
               pulse_total_ff[idx_ff] <= total_sum;
               if (delta_nz) last_edge_ff[idx_ff] <= now_w;
               if (stop_w) held_rpm_ff[idx_ff] <= '0;
            end
            ST_DIV: begin
               if (div_done) held_rpm_ff[idx_ff] <= div_quot;
            end
            default: begin
            end
         endcase
      end
   end

   // Output register: a new result loads when the register is empty or being taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_rpm_ff   <= res_rpm_ff;
         rsp_stop_ff  <= res_stop_ff;
         rsp_pmode_ff <= res_pmode_ff;
         rsp_total_ff <= res_total_ff;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.rpm_x16     = rsp_rpm_ff;
   assign rsp_bus.stopped     = rsp_stop_ff;
   assign rsp_bus.period_est  = rsp_pmode_ff;
   assign rsp_bus.pulse_tally = rsp_total_ff;

   tach_div #(
      .CW (CW),
      .TW (TW)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .delta (delta_ff),
      .gate  (gate_ff),
      .ppr   (ppr_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   // A result that is not taken keeps the sequencer waiting with its result.
   a_out_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && rsp_valid_ff && !rsp_bus.ready) |=> (state_ff == ST_OUT))
      else $error("result sequencer left the output state while the register was full");

   // The speed unit only finishes for a sample that is waiting on it.
   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("speed unit finished outside of a division");

   // A stopped result reports zero speed outside period mode.
   a_stop_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.stopped) |-> (rsp_bus.rpm_x16 == '0 && !rsp_bus.period_est))
      else $error("stopped result carries a speed");

   // Frequency mode is reported only at or above the crossover speed.
   a_freq_mode: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.stopped && !rsp_bus.period_est)
         |-> (rsp_bus.rpm_x16 >= CROSSOVER_X16))
      else $error("frequency-mode result below the crossover speed");

endmodule

// ===== tb/sv/dual_mode_tachometer_checker.sv =====
// Scoreboard that predicts each tachometer sample's speed result and checks the result channel.
module dual_mode_tachometer_checker (
   input  logic                            clock,
   input  logic                            reset,
   tach_req_if                             req_mon,
   tach_rsp_if                             rsp_mon,
   input  logic                            csr_we,
   input  logic [tach_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tach_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                              fail_count,
   output int                              pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import tach_pkg::*;

   localparam int         NUM_CHANNELS = 2;
   localparam logic [63:0] SPEED_SCALE  = 64'd960000000;
   localparam logic [63:0] SPEED_LIMIT  = 64'd1048575;
   localparam logic [63:0] FREQ_FLOOR   = 64'd9600;
   localparam logic [63:0] US_PER_MILLI = 64'd1000;

   typedef struct packed {
      logic [RPM_W-1:0]   rpm_x16;
      logic               stopped;
      logic               period_est;
      logic [TOTAL_W-1:0] pulse_tally;
   } speed_result_type;

   logic [CNT_W-1:0]   prior_count   [NUM_CHANNELS];
   logic [TS_W-1:0]    prior_time_us [NUM_CHANNELS];
   logic [TS_W-1:0]    edge_time_us  [NUM_CHANNELS];
   logic [TOTAL_W-1:0] pulse_sum     [NUM_CHANNELS];
   logic [RPM_W-1:0]   held_speed    [NUM_CHANNELS];
   logic [PPR_W-1:0]   ppr;
   logic [TMO_W-1:0]   timeout_ms;

   speed_result_type expected_speeds[$];

   // Advances one channel by one sample and returns the speed result it should report.
   function automatic speed_result_type predict_speed(input logic [CH_W-1:0]  ch,
                                                      input logic [CNT_W-1:0] count,
                                                      input logic [TS_W-1:0]  now);
      speed_result_type r;
      logic [CNT_W-1:0] delta;
      logic [TS_W-1:0]  gate;
      logic [TS_W-1:0]  since_edge;
      logic [63:0]      estimate;
      // The counter modulus is a power of two, so plain wrapping subtraction is the delta.
      delta = count - prior_count[ch];
      gate  = now - prior_time_us[ch];
      pulse_sum[ch] = pulse_sum[ch] + TOTAL_W'(delta);
      if (delta != '0) begin
         edge_time_us[ch] = now;
      end
      since_edge = now - edge_time_us[ch];
      prior_count[ch]   = count;
      prior_time_us[ch] = now;
      r.pulse_tally = pulse_sum[ch];
      if (64'(since_edge) / US_PER_MILLI >= 64'(timeout_ms)) begin
         r.rpm_x16    = '0;
         r.stopped    = 1'b1;
         r.period_est = 1'b0;
      end else begin
         r.stopped = 1'b0;
         if (delta == '0) begin
            estimate = '0;
         end else if (gate == '0 || ppr == '0) begin
            estimate = SPEED_LIMIT;
         end else begin
            estimate = (64'(delta) * SPEED_SCALE) / 64'(gate);
            estimate = estimate / 64'(ppr);
            if (estimate > SPEED_LIMIT) begin
               estimate = SPEED_LIMIT;
            end
         end
         if (estimate >= FREQ_FLOOR) begin
            r.rpm_x16    = RPM_W'(estimate);
            r.period_est = 1'b0;
         end else if (delta != '0) begin
            r.rpm_x16    = RPM_W'(estimate);
            r.period_est = 1'b1;
         end else begin
            r.rpm_x16    = held_speed[ch];
            r.period_est = 1'b1;
         end
      end
      held_speed[ch] = r.rpm_x16;
      return r;
   endfunction

   function automatic int field_differs(input string name, input logic [63:0] want,
                                        input logic [63:0] seen);
      if (want !== seen) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, seen);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      speed_result_type want;
      speed_result_type seen;
      int               errors;
      errors = 0;
      if (reset) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            prior_count[i]   = '0;
            prior_time_us[i] = '0;
            edge_time_us[i]  = '0;
            pulse_sum[i]     = '0;
            held_speed[i]    = '0;
         end
         ppr        = 8'd1;
         timeout_ms = 16'd1000;
         expected_speeds.delete();
         fail_count <= 0;
         pending    <= 0;
      end else begin
         // Results are matched before new samples are predicted, so a result can never
         // pair with a sample accepted on the same edge.
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen = '{rsp_mon.rpm_x16, rsp_mon.stopped, rsp_mon.period_est,
                     rsp_mon.pulse_tally};
            if (expected_speeds.size() == 0) begin
               $error("Unexpected speed result: rpm_x16 %0d, stopped %0b, total %0d",
                      seen.rpm_x16, seen.stopped, seen.pulse_tally);
               errors++;
            end else begin
               want = expected_speeds.pop_front();
               errors += field_differs("rpm_x16", 64'(want.rpm_x16), 64'(seen.rpm_x16));
               errors += field_differs("stopped", 64'(want.stopped), 64'(seen.stopped));
               errors += field_differs("period_est", 64'(want.period_est),
                                       64'(seen.period_est));
               errors += field_differs("pulse_tally", 64'(want.pulse_tally),
                                       64'(seen.pulse_tally));
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            expected_speeds.push_back(predict_speed(req_mon.channel, req_mon.pulse_count,
                                                    req_mon.timestamp_us));
         end
         if (csr_we) begin
            case (csr_index)
               CSR_PPR:     ppr        = csr_wdata[PPR_W-1:0];
               CSR_TIMEOUT: timeout_ms = csr_wdata[TMO_W-1:0];
               default: ;
            endcase
         end
         fail_count <= fail_count + errors;
         pending    <= expected_speeds.size();
      end
   end

endmodule

// ===== tb/sv/dual_mode_tachometer_tb.sv =====
// Top of the tachometer testbench: clock, reset, sample and register stimulus, and the verdict.
module dual_mode_tachometer_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import tach_pkg::*;

   localparam int HALF_PERIOD     = 10;
   localparam int RESET_CYCLES    = 7;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int SETTLE_CYCLES   = 50;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   tach_req_if sample_bus ();
   tach_rsp_if speed_bus ();

   int fail_count;
   int pending;
   int idle_cycles;

   // Both handshake sides read these: no_idle suppresses random gaps on either side, and
   // hold_off_request asks the receiver for one long stall of the result channel.
   bit no_idle;
   bit hold_off_request;

   // The sender's own view of each channel's last counter reading and timestamp. It only
   // shapes the stimulus into plausible sequences; the scoreboard keeps the real state.
   logic [CNT_W-1:0] shape_count [2];
   logic [TS_W-1:0]  shape_time  [2];

   always #(HALF_PERIOD) clock = ~clock;

   dual_mode_tachometer DUT (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (sample_bus),
      .rsp_bus   (speed_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   dual_mode_tachometer_checker speed_scoreboard (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (sample_bus),
      .rsp_mon    (speed_bus),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // The watchdog counts cycles in which neither channel completes a transaction. A correct
   // block never goes this long without progress, even through the long receiver stall.
   always @(posedge clock) begin
      if (reset || (sample_bus.valid && sample_bus.ready) ||
          (speed_bus.valid && speed_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("dual_mode_tachometer_tb failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // The receiver drops ready at random, except during quiet stretches. When asked, it
   // holds ready low for a long count of its own while the sender keeps offering samples,
   // so the output register fills and the block has to stall its input.
   initial begin
      speed_bus.ready = 1'b0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            speed_bus.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_off_request = 1'b0;
         end
         speed_bus.ready <= no_idle || ($urandom_range(99) >= 16);
      end
   end

   // Offers one sample transaction and returns at the falling edge after it was taken.
   // Valid stays high on return, so back-to-back samples never drop it in between.
   task automatic send_sample(input logic [CH_W-1:0] ch, input logic [CNT_W-1:0] count,
                              input logic [TS_W-1:0] stamp);
      while (!no_idle && $urandom_range(99) < 16) begin
         sample_bus.valid <= 1'b0;
         @(negedge clock);
      end
      sample_bus.valid        <= 1'b1;
      sample_bus.channel      <= ch;
      sample_bus.pulse_count  <= count;
      sample_bus.timestamp_us <= stamp;
      @(posedge clock);
      while (!sample_bus.ready) @(posedge clock);
      @(negedge clock);
      shape_count[ch] = count;
      shape_time[ch]  = stamp;
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(negedge clock);
   endtask

   // Stops offering samples and waits until every predicted result has been taken.
   task automatic drain();
      sample_bus.valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
   endtask

   // Mostly well-formed sample sequences per channel with random gaps and pulse deltas,
   // mixed with noise (any reading at any time, which also moves the time base anywhere
   // in the 48-bit range) and broken steps that repeat or rewind the time.
   task automatic run_random(input int count);
      logic [CH_W-1:0]  ch;
      logic [CNT_W-1:0] next_count;
      logic [TS_W-1:0]  next_time;
      int               kind;
      int               pick;
      for (int n = 0; n < count; n++) begin
         ch   = CH_W'($urandom_range(1));
         kind = $urandom_range(99);
         if (kind < 12) begin
            next_count = CNT_W'($urandom);
            next_time  = TS_W'({$urandom, $urandom});
         end else if (kind < 18) begin
            next_count = shape_count[ch] + CNT_W'($urandom_range(50));
            next_time  = shape_time[ch] - TS_W'($urandom_range(5000));
         end else begin
            pick = $urandom_range(9);
            if (pick <= 5) begin
               next_time = shape_time[ch] + TS_W'($urandom_range(200000, 1000));
            end else if (pick <= 7) begin
               next_time = shape_time[ch] + TS_W'($urandom_range(1000, 1));
            end else if (pick == 8) begin
               next_time = shape_time[ch] + TS_W'($urandom_range(1200000, 200000));
            end else begin
               next_time = shape_time[ch] + TS_W'($urandom_range(70000000, 1000000));
            end
            pick = $urandom_range(9);
            if (pick <= 2) begin
               next_count = shape_count[ch];
            end else if (pick <= 5) begin
               next_count = shape_count[ch] + CNT_W'($urandom_range(20, 1));
            end else if (pick <= 7) begin
               next_count = shape_count[ch] + CNT_W'($urandom_range(2000, 1));
            end else begin
               next_count = shape_count[ch] + CNT_W'($urandom_range(32767, 1));
            end
         end
         send_sample(ch, next_count, next_time);
      end
   endtask

   // A phase starts from an idle block, sets both registers, then runs random samples.
   task automatic run_phase(input logic [PPR_W-1:0] ppr, input logic [TMO_W-1:0] timeout,
                            input int count, input bit quiet, input bit hold_off);
      drain();
      write_register(CSR_PPR, CSR_DATA_W'(ppr));
      write_register(CSR_TIMEOUT, CSR_DATA_W'(timeout));
      csr_we           <= 1'b0;
      no_idle          = quiet;
      hold_off_request = hold_off;
      run_random(count);
   endtask

   initial begin
      sample_bus.valid        = 1'b0;
      sample_bus.channel      = '0;
      sample_bus.pulse_count  = '0;
      sample_bus.timestamp_us = '0;
      csr_we                  = 1'b0;
      csr_index               = CSR_PPR;
      csr_wdata               = '0;
      no_idle                 = 1'b0;
      hold_off_request        = 1'b0;
      for (int i = 0; i < 2; i++) begin
         shape_count[i] = '0;
         shape_time[i]  = '0;
      end
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed samples under the reset settings (one pulse per revolution, one second).
      // Channel 0 first reports no pulses, then frequency mode, period mode with pulses,
      // a held speed, a stop after the timeout, a zero gate with pulses, a counter wrap,
      // and the two sides of the 600 RPM crossover followed by a held period speed.
      send_sample(1'b0, 15'd0, 48'd1000);
      send_sample(1'b0, 15'd10, 48'd101000);
      send_sample(1'b0, 15'd11, 48'd1101000);
      send_sample(1'b0, 15'd11, 48'd1201000);
      send_sample(1'b0, 15'd11, 48'd2201000);
      send_sample(1'b0, 15'd12, 48'd2201000);
      send_sample(1'b0, 15'd5, 48'd2211000);
      send_sample(1'b0, 15'd6, 48'd2311000);
      send_sample(1'b0, 15'd7, 48'd2411001);
      send_sample(1'b0, 15'd7, 48'd2411002);
      // Channel 1 runs to the largest reading and time, wraps both, holds a saturated
      // speed just short of the timeout, and then stops exactly on it.
      send_sample(1'b1, 15'd32767, 48'hFFFF_FFFF_FFFF);
      send_sample(1'b1, 15'd0, 48'd500);
      send_sample(1'b1, 15'd0, 48'd1000499);
      send_sample(1'b1, 15'd0, 48'd1000500);

      // Settings phases cover both register extremes, a zero pulse count per revolution
      // and a zero timeout. The second phase opens with the long receiver stall, and one
      // phase runs with no idling on either side.
      run_phase(8'd1, 16'd65535, 300, 1'b0, 1'b0);
      run_phase(8'd255, 16'd1000, 300, 1'b0, 1'b1);
      run_phase(8'd0, 16'd1, 150, 1'b0, 1'b0);
      run_phase(8'd4, 16'd0, 100, 1'b0, 1'b0);
      run_phase(PPR_W'($urandom_range(255, 1)), TMO_W'($urandom), 300, 1'b1, 1'b0);
      run_phase(8'd60, 16'd200, 300, 1'b0, 1'b0);
      run_phase(PPR_W'($urandom_range(255, 1)), TMO_W'($urandom_range(3000)), 200,
                1'b0, 1'b0);

      drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("dual_mode_tachometer_tb passed");
      end else begin
         $display("dual_mode_tachometer_tb failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/tach_pkg.sv
rtl/tach_req_if.sv
rtl/tach_rsp_if.sv
rtl/tach_div.sv
rtl/dual_mode_tachometer.sv
tb/sv/dual_mode_tachometer_checker.sv
tb/sv/dual_mode_tachometer_tb.sv
